// ===== sv/ipatp_pkg.sv =====
// Types, character codes and the dotted-quad step shared by the address parser.
package ipatp_pkg;

    localparam logic [1:0] KIND_V4  = 2'd0;
    localparam logic [1:0] KIND_V6  = 2'd1;
    localparam logic [1:0] KIND_BAD = 2'd2;

    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CASE_BIT  = 8'h20;
    localparam logic [7:0] HEX_BIAS  = 8'h57;  // 'a' - 10

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [2:0]  DOTS_SAT   = 3'd7;
    localparam logic [2:0]  QUAD_DOTS  = 3'd3;
    localparam logic [2:0]  HEX_MAX    = 3'd4;
    localparam logic [3:0]  GROUPS     = 4'd8;
    localparam logic [3:0]  GROUPS_TAIL_MAX = 4'd7;

    typedef struct packed {
        logic [31:0] accum;
        logic [7:0]  octet;
        logic [2:0]  dots;
        logic        err;
    } quad_t;

    typedef struct packed {
        logic [7:0][15:0] groups;
        logic [3:0]       groups_done;
        logic [3:0]       gap_index;
        logic             gap_seen;
        logic [15:0]      hex_word;
        logic [2:0]       hex_digits;
        logic             colon_seen;
        logic             first_pending;
        logic             tail_mode;
        logic             v6_err;
        quad_t            tail;
        quad_t            whole;
    } state_t;

    function automatic state_t state_reset();
        state_t r;
        r = '0;
        r.first_pending = 1'b1;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // One character into a dotted-quad accumulator; errors stick.
    function automatic quad_t quad_step(input quad_t q, input logic [7:0] c);
        quad_t       r;
        logic [11:0] v;
        r = q;
        v = ({4'b0, q.octet} << 3) + ({4'b0, q.octet} << 1) + {8'b0, c[3:0]};
        if (!q.err)
        begin
            if (is_digit(c))
            begin
                if (v > OCTET_MAX)
                    r.err = 1'b1;
                else
                    r.octet = v[7:0];
            end
            else if (c == CH_DOT)
            begin
                r.accum = {q.accum[23:0], q.octet};
                r.octet = '0;
                if (q.dots != DOTS_SAT)
                    r.dots = q.dots + 3'd1;
            end
            else
            begin
                r.err = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/ipatp_parse.sv =====
// Parser state registers and the per-character update of both parsers.
module ipatp_parse
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,       // consume ch this cycle
    input  logic                step_last,  // ch ends the string
    input  logic [7:0]          ch,
    output ipatp_pkg::state_t   post        // state after ch
);

    ipatp_pkg::state_t st_reg;
    ipatp_pkg::state_t st_next;
    ipatp_pkg::state_t nx;
    logic [7:0]        lc;

    always_comb
    begin
        nx = st_reg;
        lc = ch | ipatp_pkg::CASE_BIT;
        nx.whole = ipatp_pkg::quad_step(st_reg.whole, ch);
        if (!st_reg.v6_err)
        begin
            nx.first_pending = 1'b0;
            if (st_reg.first_pending && ch == ipatp_pkg::CH_COLON)
            begin
                // lone leading colon is skipped
            end
            else if (st_reg.tail_mode)
            begin
                nx.tail = ipatp_pkg::quad_step(st_reg.tail, ch);
            end
            else if (ch == ipatp_pkg::CH_COLON)
            begin
                if (st_reg.hex_digits != 3'd0)
                begin
                    nx.groups[st_reg.groups_done[2:0]] = st_reg.hex_word;
                    nx.groups_done = st_reg.groups_done + 4'd1;
                    if (st_reg.groups_done >= ipatp_pkg::GROUPS_TAIL_MAX)
                        nx.v6_err = 1'b1;
                    nx.hex_digits = '0;
                    nx.hex_word   = '0;
                end
                else if (st_reg.gap_seen)
                begin
                    nx.v6_err = 1'b1;
                end
                else
                begin
                    nx.gap_seen  = 1'b1;
                    nx.gap_index = st_reg.groups_done;
                end
                nx.colon_seen = 1'b1;
                nx.tail       = '0;
            end
            else
            begin
                nx.tail = ipatp_pkg::quad_step(st_reg.tail, ch);
                if (ch == ipatp_pkg::CH_DOT && st_reg.hex_digits != 3'd0)
                begin
                    if (st_reg.groups_done >= ipatp_pkg::GROUPS_TAIL_MAX || !st_reg.colon_seen)
                        nx.v6_err = 1'b1;
                    else
                        nx.tail_mode = 1'b1;
                end
                else if (st_reg.hex_digits >= ipatp_pkg::HEX_MAX)
                begin
                    nx.v6_err = 1'b1;
                end
                else
                begin
                    nx.hex_digits = st_reg.hex_digits + 3'd1;
                    if (ipatp_pkg::is_digit(ch))
                        nx.hex_word = {st_reg.hex_word[11:0], ch[3:0]};
                    else if (lc >= ipatp_pkg::CH_LOW_A && lc <= ipatp_pkg::CH_LOW_F)
                        nx.hex_word = {st_reg.hex_word[11:0], 4'(lc - ipatp_pkg::HEX_BIAS)};
                    else
                        nx.v6_err = 1'b1;
                end
            end
        end
    end

    assign post = nx;

    always_comb
    begin
        st_next = st_reg;
        if (step)
            st_next = step_last ? ipatp_pkg::state_reset() : nx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ipatp_pkg::state_reset();
        else
            st_reg <= st_next;
    end

endmodule

// ===== sv/ipatp_assemble.sv =====
// Builds the result from the state after the final character: quad, expanded IPv6 or invalid.
module ipatp_assemble
(
    input  ipatp_pkg::state_t post,
    output logic [1:0]        kind,
    output logic [63:0]       addr_high,
    output logic [63:0]       addr_low
);

    logic [7:0][15:0] s;
    logic [7:0][15:0] g;
    logic [255:0]     dbl;
    logic [7:0][15:0] rot;
    logic [31:0]      tv;
    logic [3:0]       count;
    logic [3:0]       zeros;
    logic             err;

    always_comb
    begin
        s     = post.groups;
        tv    = {post.tail.accum[23:0], post.tail.octet};
        err   = post.v6_err;
        count = '0;
        if (!err)
        begin
            if (post.tail_mode)
            begin
                if (post.tail.err || post.tail.dots != ipatp_pkg::QUAD_DOTS)
                begin
                    err = 1'b1;
                end
                else
                begin
                    s[post.groups_done[2:0]]         = tv[31:16];
                    s[3'(post.groups_done + 4'd1)]   = tv[15:0];
                    count = post.groups_done + 4'd2;
                end
            end
            else if (post.hex_digits == 3'd0 && !post.gap_seen)
            begin
                err = 1'b1;
            end
            else
            begin
                s[post.groups_done[2:0]] = post.hex_word;
                count = post.groups_done + 4'd1;
            end
        end
        if (!err)
        begin
            if (count > ipatp_pkg::GROUPS)
                err = 1'b1;
            else if (count < ipatp_pkg::GROUPS && !post.gap_seen)
                err = 1'b1;
            else if (count == ipatp_pkg::GROUPS && post.gap_seen)
                err = 1'b1;
        end
        zeros = ipatp_pkg::GROUPS - count;
        // rotate so that group i of rot is s[i - zeros]
        dbl = {s, s} << {zeros[2:0], 4'b0};
        rot = dbl[255:128];
        for (int i = 0; i < 8; i++)
        begin
            if (5'(i) < {1'b0, post.gap_index})
                g[i] = s[i];
            else if (5'(i) < {1'b0, post.gap_index} + {1'b0, zeros})
                g[i] = '0;
            else
                g[i] = rot[i];
        end

        kind      = ipatp_pkg::KIND_BAD;
        addr_high = '0;
        addr_low  = '0;
        if (!post.whole.err && post.whole.dots == ipatp_pkg::QUAD_DOTS)
        begin
            kind     = ipatp_pkg::KIND_V4;
            addr_low = {32'b0, post.whole.accum[23:0], post.whole.octet};
        end
        else if (!err)
        begin
            kind      = ipatp_pkg::KIND_V6;
            addr_high = {g[0], g[1], g[2], g[3]};
            addr_low  = {g[4], g[5], g[6], g[7]};
        end
    end

endmodule

// ===== sv/ip_address_text_parser_unit.sv =====
// Top level of the IPv4/IPv6 address text parser: input register, parser, result register.
// A last character is held in the input register; its result is then registered.
// Throughput: one character per cycle; the character stage is set free every cycle
//   except when a last character waits behind an untaken result.
// Reset (rst_n low, asynchronous): all parser state cleared, input and result stages empty.
// After each last character the parser state returns to its reset value.
module ip_address_text_parser_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_in
    input  logic         s_tlast,   // last_char
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] addr_high, [127:64] addr_low
    output logic [1:0]   m_tuser    // [1:0] kind
);

    logic              in_valid_reg;
    logic              in_last_reg;
    logic [7:0]        in_char_reg;
    logic              out_valid_reg;
    logic [129:0]      out_data_reg;
    logic              adv;
    ipatp_pkg::state_t post;
    logic [1:0]        kind;
    logic [63:0]       addr_high;
    logic [63:0]       addr_low;

    // a character that ends no string never waits for the result stage
    assign adv      = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ipatp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .step_last (in_last_reg),
        .ch        (in_char_reg),
        .post      (post)
    );

    ipatp_assemble u_assemble
    (
        .post      (post),
        .kind      (kind),
        .addr_high (addr_high),
        .addr_low  (addr_low)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_last_reg)
            out_data_reg <= {addr_low, addr_high, kind};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg[1:0];
    assign m_tdata  = out_data_reg[129:2];

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg[1:0] != 2'd3)
        else $error("result kind out of range");

    a_v4_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[1:0] == ipatp_pkg::KIND_V4)
        |-> (out_data_reg[65:2] == 64'd0 && out_data_reg[129:98] == 32'd0))
        else $error("ipv4 result carries upper address bits");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[1:0] == ipatp_pkg::KIND_BAD)
        |-> out_data_reg[129:2] == 128'd0)
        else $error("invalid result carries address bits");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(adv && in_last_reg))
        else $error("result appeared without a final character");

endmodule

// ===== sim/ip_address_text_parser_unit_tb.sv =====
// Testbench for ip_address_text_parser_unit: address strings in, results checked by a predictor.
module ip_address_text_parser_unit_tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] acc;
        logic [7:0]  oct;
        logic [2:0]  dots;
        logic        bad;
    } dotted_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] hi;
        logic [63:0] lo;
    } addr_result_t;

    typedef enum {MUT_REPLACE, MUT_TRUNCATE, MUT_INSERT, MUT_REPEAT} mutation_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int error_count = 0;

    // predicted parser state
    logic [15:0] grp [8];
    logic [3:0]  n_grp;
    logic [3:0]  gap_at;
    logic        has_gap;
    logic [15:0] hex_val;
    logic [2:0]  hex_cnt;
    logic        saw_colon;
    logic        at_start;
    logic        in_tail;
    logic        v6_bad;
    dotted_t     tail_q;
    dotted_t     whole_q;

    addr_result_t pending_addrs [$];
    addr_result_t oldest;
    logic [7:0]   addr_text [$];

    ip_address_text_parser_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // long receiver hold-off, armed by the backpressure test
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_addrs.size() == 0)
            begin
                $display("%0t: unexpected transaction, tuser %h tdata %h", $time, m_tuser,
                         m_tdata);
                error_count++;
            end
            else
            begin
                oldest = pending_addrs.pop_front();
                if (m_tuser !== oldest.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, oldest.kind,
                             m_tuser);
                    error_count++;
                end
                if (m_tdata[63:0] !== oldest.hi)
                begin
                    $display("%0t: addr_high expected %h actual %h", $time, oldest.hi,
                             m_tdata[63:0]);
                    error_count++;
                end
                if (m_tdata[127:64] !== oldest.lo)
                begin
                    $display("%0t: addr_low expected %h actual %h", $time, oldest.lo,
                             m_tdata[127:64]);
                    error_count++;
                end
            end
        end
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic dotted_t dotted_next(input dotted_t q, input logic [7:0] c);
        dotted_t r;
        int      v;
        r = q;
        v = int'(q.oct) * 10 + int'(c) - int'(ipatp_pkg::CH_ZERO);
        if (!q.bad)
        begin
            if (c >= ipatp_pkg::CH_ZERO && c <= ipatp_pkg::CH_NINE)
            begin
                if (v > int'(ipatp_pkg::OCTET_MAX))
                    r.bad = 1'b1;
                else
                    r.oct = v[7:0];
            end
            else if (c == ipatp_pkg::CH_DOT)
            begin
                r.acc = {q.acc[23:0], q.oct};
                r.oct = '0;
                if (q.dots != ipatp_pkg::DOTS_SAT)
                    r.dots = q.dots + 3'd1;
            end
            else
            begin
                r.bad = 1'b1;
            end
        end
        return r;
    endfunction

    task clear_parser;
        foreach (grp[i])
            grp[i] = '0;
        n_grp = '0;
        gap_at = '0;
        has_gap = 1'b0;
        hex_val = '0;
        hex_cnt = '0;
        saw_colon = 1'b0;
        at_start = 1'b1;
        in_tail = 1'b0;
        v6_bad = 1'b0;
        tail_q = '0;
        whole_q = '0;
    endtask

    // Advances the predicted state by one accepted character; a last character
    // queues the address the block must report.
    task parse_char(input logic [7:0] c, input logic is_last);
        logic [7:0]   lc;
        logic [7:0]   nib;
        logic         skip;
        logic         err;
        int           cnt;
        int           zeros;
        logic [31:0]  tv;
        logic [15:0]  g [8];
        addr_result_t res;
        whole_q = dotted_next(whole_q, c);
        if (!v6_bad)
        begin
            skip = 1'b0;
            if (at_start)
            begin
                at_start = 1'b0;
                skip = (c == ipatp_pkg::CH_COLON);
            end
            if (skip)
            begin
            end
            else if (in_tail)
            begin
                tail_q = dotted_next(tail_q, c);
            end
            else if (c == ipatp_pkg::CH_COLON)
            begin
                if (hex_cnt != 0)
                begin
                    grp[n_grp[2:0]] = hex_val;
                    n_grp = n_grp + 4'd1;
                    if (n_grp >= ipatp_pkg::GROUPS)
                        v6_bad = 1'b1;
                    hex_cnt = '0;
                    hex_val = '0;
                end
                else if (has_gap)
                begin
                    v6_bad = 1'b1;
                end
                else
                begin
                    has_gap = 1'b1;
                    gap_at = n_grp;
                end
                saw_colon = 1'b1;
                tail_q = '0;
            end
            else
            begin
                // text after the last colon is also tracked as a possible quad
                tail_q = dotted_next(tail_q, c);
                if (c == ipatp_pkg::CH_DOT && hex_cnt != 0)
                begin
                    if (n_grp >= ipatp_pkg::GROUPS_TAIL_MAX || !saw_colon)
                        v6_bad = 1'b1;
                    else
                        in_tail = 1'b1;
                end
                else if (hex_cnt >= ipatp_pkg::HEX_MAX)
                begin
                    v6_bad = 1'b1;
                end
                else
                begin
                    hex_cnt = hex_cnt + 3'd1;
                    lc = c | ipatp_pkg::CASE_BIT;
                    if (c >= ipatp_pkg::CH_ZERO && c <= ipatp_pkg::CH_NINE)
                    begin
                        hex_val = {hex_val[11:0], c[3:0]};
                    end
                    else if (lc >= ipatp_pkg::CH_LOW_A && lc <= ipatp_pkg::CH_LOW_F)
                    begin
                        nib = lc - ipatp_pkg::HEX_BIAS;
                        hex_val = {hex_val[11:0], nib[3:0]};
                    end
                    else
                    begin
                        v6_bad = 1'b1;
                    end
                end
            end
        end
        if (is_last)
        begin
            res.kind = ipatp_pkg::KIND_BAD;
            res.hi = '0;
            res.lo = '0;
            if (!whole_q.bad && whole_q.dots == ipatp_pkg::QUAD_DOTS)
            begin
                res.kind = ipatp_pkg::KIND_V4;
                res.lo = {32'b0, whole_q.acc[23:0], whole_q.oct};
            end
            else
            begin
                err = v6_bad;
                cnt = 0;
                if (!err)
                begin
                    if (in_tail)
                    begin
                        if (tail_q.bad || tail_q.dots != ipatp_pkg::QUAD_DOTS)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            tv = {tail_q.acc[23:0], tail_q.oct};
                            grp[n_grp[2:0]] = tv[31:16];
                            grp[3'(n_grp + 4'd1)] = tv[15:0];
                            cnt = n_grp + 2;
                        end
                    end
                    else if (hex_cnt == 0 && !has_gap)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        grp[n_grp[2:0]] = hex_val;
                        cnt = n_grp + 1;
                    end
                end
                if (!err && (cnt > int'(ipatp_pkg::GROUPS)
                             || (cnt < int'(ipatp_pkg::GROUPS) && !has_gap)
                             || (cnt == int'(ipatp_pkg::GROUPS) && has_gap)))
                    err = 1'b1;
                if (!err)
                begin
                    // expand the gap to zero groups
                    zeros = int'(ipatp_pkg::GROUPS) - cnt;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (i < int'(gap_at))
                            g[i] = grp[i];
                        else if (i < int'(gap_at) + zeros)
                            g[i] = '0;
                        else
                            g[i] = grp[i - zeros];
                    end
                    res.kind = ipatp_pkg::KIND_V6;
                    res.hi = {g[0], g[1], g[2], g[3]};
                    res.lo = {g[4], g[5], g[6], g[7]};
                end
            end
            pending_addrs.push_back(res);
            clear_parser();
        end
    endtask

    task send_char(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        parse_char(c, is_last);
    endtask

    task send_text;
        for (int i = 0; i < addr_text.size(); i++)
            send_char(addr_text[i], i == addr_text.size() - 1);
    endtask

    task automatic put_decimal(input int v);
        logic [7:0] d [$];
        do
        begin
            d.push_front(ipatp_pkg::CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (d[i])
            addr_text.push_back(d[i]);
    endtask

    // dotted quad, mostly well formed: a few empty, oversized or extreme octets, or 3 or 5 octets
    task put_quad;
        int n;
        int r;
        n = 4;
        r = $urandom_range(99);
        if (r < 4)
            n = 3;
        else if (r < 8)
            n = 5;
        for (int i = 0; i < n; i++)
        begin
            if (i != 0)
                addr_text.push_back(ipatp_pkg::CH_DOT);
            r = $urandom_range(99);
            if (r >= 6)
            begin
                if ($urandom_range(9) == 0)
                    addr_text.push_back(ipatp_pkg::CH_ZERO);
                if (r < 11)
                    put_decimal($urandom_range(256, 999));
                else if (r < 21)
                    put_decimal((r % 2) ? 255 : 0);
                else
                    put_decimal($urandom_range(0, 255));
            end
        end
    endtask

    task put_groups(input int n);
        int          ndig;
        logic [19:0] v;
        logic [3:0]  nib;
        logic [7:0]  ch;
        for (int i = 0; i < n; i++)
        begin
            if (i != 0)
                addr_text.push_back(ipatp_pkg::CH_COLON);
            ndig = ($urandom_range(99) < 3) ? 5 : $urandom_range(1, 4);
            v = 20'($urandom);
            for (int k = ndig - 1; k >= 0; k--)
            begin
                nib = v[4*k +: 4];
                if (nib < 4'd10)
                begin
                    ch = ipatp_pkg::CH_ZERO + {4'b0, nib};
                end
                else
                begin
                    ch = ipatp_pkg::HEX_BIAS + {4'b0, nib};
                    if ($urandom_range(1))
                        ch = ch & ~ipatp_pkg::CASE_BIT;
                end
                addr_text.push_back(ch);
            end
        end
    endtask

    task put_v6;
        int   need;
        int   total;
        int   b;
        logic quad;
        quad = ($urandom_range(3) == 0);
        need = quad ? 6 : 8;
        if ($urandom_range(9) == 0)
            addr_text.push_back(ipatp_pkg::CH_COLON);
        if ($urandom_range(1))
        begin
            // total == need overfills the gap on purpose
            total = $urandom_range(0, need);
            b = $urandom_range(0, total);
            put_groups(b);
            addr_text.push_back(ipatp_pkg::CH_COLON);
            addr_text.push_back(ipatp_pkg::CH_COLON);
            put_groups(total - b);
            if (quad)
            begin
                if (total - b > 0)
                    addr_text.push_back(ipatp_pkg::CH_COLON);
                put_quad();
            end
        end
        else
        begin
            put_groups(need);
            if (quad)
            begin
                addr_text.push_back(ipatp_pkg::CH_COLON);
                put_quad();
            end
        end
    endtask

    function automatic logic [7:0] pick_char();
        unique case ($urandom_range(9))
            0, 1, 2: return ipatp_pkg::CH_COLON;
            3, 4:    return ipatp_pkg::CH_DOT;
            5:       return ipatp_pkg::CH_ZERO + 8'($urandom_range(9));
            6:       return ipatp_pkg::HEX_BIAS + 8'($urandom_range(10, 15));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task send_random_addresses(input int n_chars);
        int        sent;
        int        r;
        int        pos;
        mutation_t op;
        sent = 0;
        while (sent < n_chars)
        begin
            addr_text.delete();
            r = $urandom_range(99);
            if (r < 35)
            begin
                put_quad();
            end
            else if (r < 78)
            begin
                put_v6();
            end
            else if (r < 90)
            begin
                // likely broken address: one edit on a generated quad or IPv6 text
                if (r % 2)
                    put_quad();
                else
                    put_v6();
                pos = $urandom_range(addr_text.size() - 1);
                op = mutation_t'($urandom_range(3));
                unique case (op)
                    MUT_REPLACE:  addr_text[pos] = pick_char();
                    MUT_TRUNCATE:
                        while (addr_text.size() > pos + 1)
                            void'(addr_text.pop_back());
                    MUT_INSERT:   addr_text.insert(pos, pick_char());
                    default:      addr_text.insert(pos, addr_text[pos]);
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    addr_text.push_back(pick_char());
            end
            sent += addr_text.size();
            send_text();
        end
    endtask

    task test_directed_cases;
        string cases [4];
        cases = '{"...", ":a::1.2.3.4", "256", "255.255.255.255"};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (cases[i])
        begin
            addr_text.delete();
            for (int k = 0; k < cases[i].len(); k++)
                addr_text.push_back(cases[i][k]);
            send_text();
        end
        addr_text.delete();
        addr_text.push_back(8'h00);
        send_text();
        addr_text.delete();
        addr_text.push_back(8'hff);
        send_text();
    endtask

    task test_steady_stream;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_addresses(350);
    endtask

    task test_sender_gaps;
        send_idle_pct = 71;
        recv_stall_pct = 0;
        send_random_addresses(350);
    endtask

    task test_receiver_stalls;
        send_idle_pct = 0;
        recv_stall_pct = 71;
        send_random_addresses(350);
    endtask

    task test_input_backpressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left <= 300;
        repeat (12)
        begin
            addr_text.delete();
            put_quad();
            send_text();
        end
    endtask

    task test_both_sides_idle;
        send_idle_pct = 6;
        recv_stall_pct = 6;
        send_random_addresses(350);
    endtask

    initial
    begin
        clear_parser();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_steady_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_input_backpressure();
        test_both_sides_idle();
        s_tvalid <= 1'b0;
        while (pending_addrs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
